// ===== rtl/plcs_pkg.sv =====
// plcs_pkg: shared types, constants and CRC-16 helpers for the packet length CRC signer.
// Depends on nothing; every rtl file imports it.
package plcs_pkg;

	localparam int unsigned MAX_FRAME_BYTES_DEF = 1024;
	localparam int unsigned KEY_FILL_COUNT_DEF  = 32;

	localparam logic [15:0] CRC_POLY       = 16'h1021;
	localparam logic [15:0] CRC_INIT_RST   = 16'h1021;
	localparam logic [7:0]  KEY_FILL_RST   = 8'h30;
	localparam logic [7:0]  HDR_BYTE0      = 8'hFE;
	localparam logic [7:0]  HDR_BYTE1      = 8'hF0;
	localparam logic [16:0] LENGTH_ADD     = 17'd4;

	localparam int unsigned PADDR_W = 3;
	localparam logic REG_CRC_INIT = 1'b0;
	localparam logic REG_KEY_FILL = 1'b1;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic [10:0] frame_bytes;
		logic        last_byte;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} out_word_t;

	typedef struct packed {
		logic      push;
		out_word_t word;
	} push_t;

	typedef struct packed {
		logic        start;
		logic [15:0] crc;
	} trl_start_t;

	typedef struct packed {
		logic [15:0] crc_init;
		logic [7:0]  key_fill;
	} cfg_t;

	// One byte into an MSB-first CRC-16, no reflection.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

	// n copies of byte b; only called with constant arguments.
	function automatic logic [15:0] crc_run(input logic [15:0] crc, input logic [7:0] b,
			input int unsigned n);
		logic [15:0] c;
		c = crc;
		for (int unsigned k = 0; k < n; k++) begin
			c = crc_byte(c, b);
		end
		return c;
	endfunction

endpackage

// ===== rtl/plcs_regs.sv =====
// plcs_regs: APB-style configuration registers (crc_init, key fill byte).
// Depends on plcs_pkg.
module plcs_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [plcs_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output plcs_pkg::cfg_t               cfg
);
	import plcs_pkg::*;

	logic [15:0] crc_init_q;
	logic [7:0]  key_fill_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_init_q <= CRC_INIT_RST;
			key_fill_q <= KEY_FILL_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_CRC_INIT: crc_init_q <= pwdata[15:0];
				REG_KEY_FILL: key_fill_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_CRC_INIT: prdata = {16'h0000, crc_init_q};
			REG_KEY_FILL: prdata = {24'h000000, key_fill_q};
			default:      prdata = '0;
		endcase
	end

	assign cfg.crc_init = crc_init_q;
	assign cfg.key_fill = key_fill_q;

endmodule

// ===== rtl/plcs_framer.sv =====
// plcs_framer: header substitution, byte position and running packet CRC.
// Depends on plcs_pkg.
module plcs_framer #(
	parameter int unsigned MAX_FRAME_BYTES = plcs_pkg::MAX_FRAME_BYTES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  plcs_pkg::in_word_t     item,
	input  logic [15:0]            crc_init,
	output plcs_pkg::out_word_t    word,
	output plcs_pkg::trl_start_t   start
);
	import plcs_pkg::*;

	localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES + 1);

	logic [POS_W-1:0] pos_q;
	logic [15:0]      len_q;
	logic [15:0]      crc_q;
	logic [16:0]      len_sum;
	logic [15:0]      len_new;
	logic [15:0]      crc_base;
	logic [15:0]      crc_new;
	logic [7:0]       b;

	assign len_sum  = 17'(item.frame_bytes) + LENGTH_ADD;
	assign len_new  = len_sum[16] ? 16'hFFFF : len_sum[15:0];
	assign crc_base = (pos_q == '0) ? crc_init : crc_q;

	always_comb begin
		case (pos_q)
			POS_W'(0): b = HDR_BYTE0;
			POS_W'(1): b = HDR_BYTE1;
			POS_W'(2): b = len_q[7:0];
			POS_W'(3): b = len_q[15:8];
			default:   b = item.data_byte;
		endcase
	end

	assign crc_new = crc_byte(crc_base, b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			if (item.last_byte) begin
				pos_q <= '0;
			end else if (pos_q < POS_W'(MAX_FRAME_BYTES)) begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			crc_q <= crc_new;
			if (pos_q == '0) begin
				len_q <= len_new;
			end
		end
	end

	assign word.out_byte = b;
	assign word.out_last = 1'b0;
	assign start.start   = accept && item.last_byte;
	assign start.crc     = crc_new;

endmodule

// ===== rtl/plcs_trailer.sv =====
// plcs_trailer: sequences the four trailer bytes (packet CRC, key CRC).
// Key CRC over the fill run uses a constant XOR matrix. Depends on plcs_pkg.
module plcs_trailer #(
	parameter int unsigned KEY_FILL_COUNT = plcs_pkg::KEY_FILL_COUNT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  plcs_pkg::trl_start_t start,
	input  plcs_pkg::cfg_t       cfg,
	input  logic                 space,
	output logic                 busy,
	output plcs_pkg::push_t      push
);
	import plcs_pkg::*;

	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_CRC_LO = 3'd1;
	localparam logic [2:0] PH_CRC_HI = 3'd2;
	localparam logic [2:0] PH_KEY_LO = 3'd3;
	localparam logic [2:0] PH_KEY_HI = 3'd4;

	logic [2:0]  phase_q;
	logic [15:0] crc_q;
	logic [15:0] kcrc_q;
	logic [15:0] key_next;
	logic [15:0] key_cols [16];
	logic [15:0] fill_cols [8];

	// Fill run is linear: state part and fill-byte part add up.
	for (genvar j = 0; j < 16; j++) begin : g_key_col
		localparam logic [15:0] COL = crc_run(16'h0001 << j, 8'h00, KEY_FILL_COUNT);
		assign key_cols[j] = COL;
	end
	for (genvar i = 0; i < 8; i++) begin : g_fill_col
		localparam logic [15:0] COL = crc_run(16'h0000, 8'h01 << i, KEY_FILL_COUNT);
		assign fill_cols[i] = COL;
	end

	always_comb begin
		key_next = '0;
		for (int j = 0; j < 16; j++) begin
			if (kcrc_q[j]) key_next ^= key_cols[j];
		end
		for (int i = 0; i < 8; i++) begin
			if (cfg.key_fill[i]) key_next ^= fill_cols[i];
		end
	end

	assign busy = (phase_q != PH_IDLE);

	always_comb begin
		push = '0;
		unique case (phase_q)
			PH_CRC_LO: push = '{push: space, word: '{out_byte: crc_q[7:0], out_last: 1'b0}};
			PH_CRC_HI: push = '{push: space, word: '{out_byte: crc_q[15:8], out_last: 1'b0}};
			PH_KEY_LO: push = '{push: space, word: '{out_byte: key_next[7:0], out_last: 1'b0}};
			PH_KEY_HI: push = '{push: space, word: '{out_byte: kcrc_q[15:8], out_last: 1'b1}};
			default:   push = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else if (start.start) begin
			phase_q <= PH_CRC_LO;
		end else if (busy && space) begin
			unique case (phase_q)
				PH_CRC_LO: phase_q <= PH_CRC_HI;
				PH_CRC_HI: phase_q <= PH_KEY_LO;
				PH_KEY_LO: phase_q <= PH_KEY_HI;
				default:   phase_q <= PH_IDLE;
			endcase
		end
	end

	// kcrc_q: crc_init over CRC low, then high, then the full key value.
	always_ff @(posedge clk) begin
		if (start.start) begin
			crc_q <= start.crc;
		end else if (busy && space) begin
			case (phase_q)
				PH_CRC_LO: kcrc_q <= crc_byte(cfg.crc_init, crc_q[7:0]);
				PH_CRC_HI: kcrc_q <= crc_byte(kcrc_q, crc_q[15:8]);
				PH_KEY_LO: kcrc_q <= key_next;
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/plcs_obuf.sv =====
// plcs_obuf: two-word output buffer; holds results while the sink stalls.
// Depends on plcs_pkg.
module plcs_obuf (
	input  logic                clk,
	input  logic                arst_n,
	input  plcs_pkg::push_t     push,
	output logic                space,
	output logic                result_valid,
	input  logic                result_ready,
	output plcs_pkg::out_word_t result
);
	import plcs_pkg::*;

	out_word_t  ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign space        = (cnt_q != 2'd2);
	assign result_valid = (cnt_q != 2'd0);
	assign result       = ent_q[rd_q];
	assign pop          = result_valid && result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push.push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			case ({push.push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push.push) begin
			ent_q[wr_q] <= push.word;
		end
	end

endmodule

// ===== rtl/packet_length_crc_signer.sv =====
// packet_length_crc_signer: frames a command packet with header and length and signs it
// with a packet CRC-16 and a key CRC-16. Depends on plcs_pkg and the plcs_* submodules.
//
//  channel  | signals                                      | word
//  ---------+----------------------------------------------+---------------------------------
//  item     | item_valid, item_ready, item                 | data_byte, frame_bytes, last_byte
//  result   | result_valid, result_ready, result           | out_byte, out_last
//  config   | psel, penable, pwrite, paddr, pwdata, prdata | crc_init @0x0, key_fill @0x4
//
// One byte per cycle while the output buffer has space: an ordinary item leaves one word
// and item_ready stays high. An item with last_byte set adds four trailer words; item_ready
// is low while the trailer sequencer pushes them into the output buffer.
// Output words are registered in the two-word output buffer.
// Result stalls hold in that buffer; item_ready drops only once both entries are full.
// Reset clears control state and loads crc_init 0x1021 and key fill 0x30.
module packet_length_crc_signer #(
	parameter int unsigned MAX_FRAME_BYTES = plcs_pkg::MAX_FRAME_BYTES_DEF,
	parameter int unsigned KEY_FILL_COUNT  = plcs_pkg::KEY_FILL_COUNT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_ready,
	input  plcs_pkg::in_word_t           item,
	output logic                         result_valid,
	input  logic                         result_ready,
	output plcs_pkg::out_word_t          result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [plcs_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import plcs_pkg::*;

	cfg_t       cfg;
	out_word_t  frm_word;
	trl_start_t trl_start;
	push_t      trl_push;
	push_t      buf_push;
	logic       trl_busy;
	logic       space;
	logic       accept;

	assign item_ready = !trl_busy && space;
	assign accept     = item_valid && item_ready;
	assign buf_push   = accept ? push_t'{push: 1'b1, word: frm_word} : trl_push;

	plcs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	plcs_framer #(
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES)
	) u_framer (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (item),
		.crc_init (cfg.crc_init),
		.word     (frm_word),
		.start    (trl_start)
	);

	plcs_trailer #(
		.KEY_FILL_COUNT (KEY_FILL_COUNT)
	) u_trailer (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (trl_start),
		.cfg    (cfg),
		.space  (space),
		.busy   (trl_busy),
		.push   (trl_push)
	);

	plcs_obuf u_obuf (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (buf_push),
		.space        (space),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// ===== rtl/plcs_checker.sv =====
// plcs_checker: port-level assertions for packet_length_crc_signer, attached by bind.
// Depends on plcs_pkg.
module plcs_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         item_valid,
	input logic                         item_ready,
	input plcs_pkg::in_word_t           item,
	input logic                         result_valid,
	input logic                         result_ready,
	input plcs_pkg::out_word_t          result,
	input logic                         psel,
	input logic                         penable,
	input logic                         pready
);
	import plcs_pkg::*;

	// A stalled result word must hold.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result word changed while stalled");

	// The last packet byte is followed by four trailer words; no input meanwhile.
	a_trailer_gap: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item.last_byte
			|=> !item_ready ##1 !item_ready ##1 !item_ready ##1 !item_ready)
		else $error("input accepted during trailer");

	// Nothing is offered right after reset.
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !result_valid)
		else $error("result valid out of reset");

	// Config port never inserts wait states.
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable |-> pready)
		else $error("pready low during access");

endmodule

bind packet_length_crc_signer plcs_checker u_plcs_checker (.*);

// ===== sim/packet_length_crc_signer_tb.sv =====
// Self-checking bench for packet_length_crc_signer: framing, packet CRC and key CRC trailer
// are checked word by word against a scoreboard with its own CRC-16.
// Depends on plcs_pkg and the rtl top level.
module packet_length_crc_signer_tb;
	import plcs_pkg::*;

	class frame_signer_board;
		logic [15:0] crc_seed;
		logic [7:0]  fill_byte;
		logic [15:0] frame_crc;
		logic [15:0] length_field;
		int unsigned position;
		out_word_t   framed_bytes[$];
		int unsigned failures;
		int unsigned checked;
		int unsigned frames;

		function new();
			crc_seed = 16'h1021;
			fill_byte = 8'h30;
			frame_crc = crc_seed;
			length_field = '0;
			position = 0;
			failures = 0;
			checked = 0;
			frames = 0;
		endfunction

		// MSB first, poly 0x1021, one data bit per shift
		function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
			logic fb;
			for (int i = 7; i >= 0; i--) begin
				fb = c[15] ^ b[i];
				c = {c[14:0], 1'b0};
				if (fb)
					c = c ^ 16'h1021;
			end
			return c;
		endfunction

		function void push(logic [7:0] b, logic l);
			out_word_t w;
			w.out_byte = b;
			w.out_last = l;
			framed_bytes.insert(framed_bytes.size(), w);
		endfunction

		function int unsigned pending();
			return framed_bytes.size();
		endfunction

		function void note_item(in_word_t w);
			logic [7:0]  b;
			logic [15:0] key;
			logic [16:0] len;
			if (position == 0) begin
				len = {6'd0, w.frame_bytes} + 17'd4;
				length_field = len[16] ? 16'hFFFF : len[15:0];
				frame_crc = crc_seed;
			end
			case (position)
				0: b = HDR_BYTE0;
				1: b = HDR_BYTE1;
				2: b = length_field[7:0];
				3: b = length_field[15:8];
				default: b = w.data_byte;
			endcase
			frame_crc = crc_step(frame_crc, b);
			push(b, 1'b0);
			if (position < MAX_FRAME_BYTES_DEF)
				position++;
			if (w.last_byte) begin
				// key CRC restarts from the current seed, so a seed written mid-frame counts here
				key = crc_step(crc_seed, frame_crc[7:0]);
				key = crc_step(key, frame_crc[15:8]);
				repeat (KEY_FILL_COUNT_DEF) key = crc_step(key, fill_byte);
				push(frame_crc[7:0], 1'b0);
				push(frame_crc[15:8], 1'b0);
				push(key[7:0], 1'b0);
				push(key[15:8], 1'b1);
				position = 0;
				frame_crc = crc_seed;
				frames++;
			end
		endfunction

		function void check_byte(out_word_t got);
			out_word_t want;
			if (framed_bytes.size() == 0) begin
				failures++;
				$display("%0t: expected no word, got byte=%02h last=%0b", $time,
					got.out_byte, got.out_last);
				return;
			end
			want = framed_bytes.pop_front();
			checked++;
			if (got.out_byte !== want.out_byte) begin
				failures++;
				$display("%0t: out_byte expected %02h got %02h", $time, want.out_byte,
					got.out_byte);
			end
			if (got.out_last !== want.out_last) begin
				failures++;
				$display("%0t: out_last expected %0b got %0b", $time, want.out_last,
					got.out_last);
			end
		endfunction
	endclass

	localparam int unsigned QUIET_LIMIT = 2000;
	localparam int unsigned HOLD_CYCLES = 60;
	localparam logic [PADDR_W-1:0] ADDR_CRC_INIT = {REG_CRC_INIT, 2'b00};
	localparam logic [PADDR_W-1:0] ADDR_KEY_FILL = {REG_KEY_FILL, 2'b00};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               item_valid = 1'b0;
	logic               item_ready;
	in_word_t           item = '0;
	logic               result_valid;
	logic               result_ready = 1'b0;
	out_word_t          result;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	frame_signer_board board = new();
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned holds_asked = 0;
	int unsigned holds_taken = 0;
	int unsigned bytes_in = 0;
	int unsigned settings = 0;

	packet_length_crc_signer dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && item_ready) begin
				board.note_item(item);
				bytes_in++;
			end
			if (result_valid && result_ready)
				board.check_byte(result);
		end
	end

	// receiver: random stalls, plus long hold-offs on request
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (holds_taken != holds_asked) begin
				holds_taken = holds_asked;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else
				result_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin
		int unsigned quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((item_valid && item_ready) || (result_valid && result_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT)
				break;
		end
		$display("%0t: timeout, no word moved for %0d cycles", $time, QUIET_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	// all driving tasks start and end at a falling edge
	task automatic send_byte(input logic [7:0] data, input logic [10:0] count, input logic last);
		in_word_t w;
		w.data_byte = data;
		w.frame_bytes = count;
		w.last_byte = last;
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item <= w;
		item_valid <= 1'b1;
		do
			@(posedge clk);
		while (!item_ready);
		@(negedge clk);
	endtask

	task automatic send_frame(input int unsigned len, input logic close);
		logic [10:0] count;
		count = ($urandom_range(99) < 80) ? len[10:0] : 11'($urandom_range(2047));
		for (int unsigned k = 0; k < len; k++)
			send_byte(8'($urandom_range(255)), count, close && (k == len - 1));
	endtask

	task automatic random_frames(input int unsigned budget);
		int unsigned sent;
		int unsigned len;
		sent = 0;
		while (sent < budget) begin
			case ($urandom_range(9))
				0: len = $urandom_range(1, 3);
				1, 2: len = $urandom_range(13, 40);
				default: len = $urandom_range(4, 12);
			endcase
			send_frame(len, 1'b1);
			sent += len;
		end
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_signing(input logic [15:0] seed, input logic [7:0] fill);
		apb_write(ADDR_CRC_INIT, {16'd0, seed});
		apb_write(ADDR_KEY_FILL, {24'd0, fill});
		board.crc_seed = seed;
		board.fill_byte = fill;
		settings++;
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: short frames, count field extremes, count mismatch, reset seed
		send_byte(8'h00, 11'd0, 1'b1);
		send_byte(8'hFF, 11'd2047, 1'b0);
		send_byte(8'hFF, 11'd0, 1'b1);
		send_byte(8'h12, 11'd1024, 1'b0);
		send_byte(8'h34, 11'd1, 1'b0);
		send_byte(8'h56, 11'd2, 1'b1);
		repeat (4) send_byte(8'h00, 11'd5, 1'b0);
		send_byte(8'hFF, 11'd5, 1'b1);
		repeat (4) send_byte(8'hFF, 11'd3, 1'b0);
		send_byte(8'h00, 11'd3, 1'b0);
		send_byte(8'hAA, 11'd3, 1'b1);
		// leave a frame open across a seed change
		repeat (3) send_byte(8'h5A, 11'd9, 1'b0);
		drain();
		set_signing(16'hFFFF, 8'h00);
		send_frame(6, 1'b1);

		// no idling; a long receiver hold-off while frames keep coming
		random_frames(50);
		send_frame(40, 1'b1);
		holds_asked++;
		send_frame(30, 1'b1);
		drain();
		random_frames(30);
		drain();

		set_signing(16'h0000, 8'hFF);
		send_idle_pct = 83;
		random_frames(100);
		drain();

		set_signing(16'($urandom_range(65535)), 8'($urandom_range(255)));
		send_idle_pct = 0;
		stall_pct = 83;
		random_frames(100);
		drain();

		set_signing(16'($urandom_range(65535)), 8'($urandom_range(255)));
		send_idle_pct = 8;
		stall_pct = 8;
		random_frames(100);
		holds_asked++;
		send_frame(20, 1'b1);
		drain();

		repeat (8) @(posedge clk);
		$display("covered %0d frames from %0d input bytes over %0d seed/fill settings",
			board.frames, bytes_in, settings);
		$display("%0d output words checked, %0d mismatches", board.checked, board.failures);
		if (board.failures == 0 && board.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

// ===== filelist.f =====
rtl/plcs_pkg.sv
rtl/plcs_regs.sv
rtl/plcs_framer.sv
rtl/plcs_trailer.sv
rtl/plcs_obuf.sv
rtl/packet_length_crc_signer.sv
rtl/plcs_checker.sv
sim/packet_length_crc_signer_tb.sv
